// ===== design/mwlfo_pkg.sv =====
// Package for the multiwave interpolated LFO: widths, constants, states, helpers.
// No dependencies.
package mwlfo_pkg;
   localparam int Voices = 8;
   localparam int VoiceW = 3;
   localparam int MaxRun = 24;
   localparam int RunW = 5;
   localparam int ValW = 26;
   localparam int StepW = 23;
   localparam logic [StepW-1:0] StepReset = 23'd121736;
   localparam logic signed [ValW-1:0] One = 26'sh100_0000;
   localparam logic signed [ValW-1:0] MinusOne = -26'sh100_0000;
   localparam logic signed [ValW-1:0] VMax = 26'sh1FF_FFFF;
   localparam logic signed [ValW-1:0] VMin = -26'sh200_0000;
   localparam logic [15:0] LfsrSeed = 16'hACE1;
   localparam logic [15:0] LfsrTaps = 16'hB400;

   localparam logic [1:0] QuadRise = 2'd0;
   localparam logic [1:0] QuadTop = 2'd1;
   localparam logic [1:0] QuadFall = 2'd2;
   localparam logic [1:0] QuadBottom = 2'd3;

   // per-voice record: 1+2+1+26*5 control/targets + 5*26 previous outputs
   // previous outputs are raw bits, read through $signed
   typedef struct packed {
      logic                   trig_seen;
      logic [1:0]             quad;
      logic                   falling;
      logic signed [ValW-1:0] tri_val;
      logic signed [ValW-1:0] saw_val;
      logic signed [ValW-1:0] rect_tgt;
      logic signed [ValW-1:0] hold_tgt;
      logic signed [ValW-1:0] sine_tgt;
      logic [4:0][ValW-1:0]   prev;
   } voice_rec_type;

   typedef enum logic [2:0] {
      ST_IDLE, ST_READ, ST_CALC, ST_MUL, ST_EMIT, ST_CLEAR
   } state_type;

   function automatic logic signed [ValW-1:0] sat26(input logic signed [ValW+1:0] x);
      if (x > ValW'(VMax)) return VMax;
      else if (x < $signed({{2{VMin[ValW-1]}}, VMin})) return VMin;
      else return x[ValW-1:0];
   endfunction

   function automatic logic signed [15:0] to_q14(input logic signed [ValW:0] v);
      logic signed [ValW-10:0] q;
      q = (ValW-9)'(v >>> 10);
      if (q > 17'sd32767) return 16'sh7FFF;
      else if (q < -17'sd32768) return 16'sh8000;
      else return q[15:0];
   endfunction
endpackage

// ===== design/multiwave_lfo_interpolated.sv =====
// Multiwave interpolated LFO top level: per-voice state memory, step logic
// and interpolation sequencer. Depends on mwlfo_pkg.
//
// Each request advances one voice by one control step and then produces
// run_length response transactions, clamped to 1..24. Per request: the accept
// in ST_IDLE, a memory read (ST_READ), an update (ST_CALC) and a multiply
// (ST_MUL), then the run. Every sample runs five channels through a shared
// 32-bit restoring divider, a load step and then one quotient bit per cycle.
// While a response waits for rsp_ready the divider pauses, and a new request
// may be accepted behind the last response of a run. After reset the voice
// memory is cleared, one voice at a time, before requests are taken.
module multiwave_lfo_interpolated (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         csr_valid,
   output logic                         csr_ready,
   input  logic [mwlfo_pkg::StepW-1:0]  csr_tri_step,
   input  logic                         req_valid,
   output logic                         req_ready,
   input  logic [2:0]                   req_voice,
   input  logic                         req_trigger_high,
   input  logic [4:0]                   req_run_length,
   output logic                         rsp_valid,
   input  logic                         rsp_ready,
   output logic signed [15:0]           rsp_sine_out,
   output logic signed [15:0]           rsp_triangle_out,
   output logic signed [15:0]           rsp_saw_up_out,
   output logic signed [15:0]           rsp_saw_down_out,
   output logic signed [15:0]           rsp_rect_out,
   output logic signed [15:0]           rsp_random_hold_out,
   output logic [2:0]                   rsp_voice_out,
   output logic                         rsp_last_sample
);
   import mwlfo_pkg::*;

   voice_rec_type mem [Voices];
   voice_rec_type rd_ff, rec_ff, rec_in;
   logic [VoiceW-1:0] wr_addr;
   logic wr_en;
   voice_rec_type wr_data;

   state_type state_ff, state_in;
   logic [StepW-1:0] step_ff;
   logic [15:0] lfsr_ff, lfsr_in;
   logic [VoiceW-1:0] voice_ff, voice_in;
   logic trig_ff, trig_in;
   logic [RunW-1:0] k_ff, k_in, i_ff, i_in;
   logic [VoiceW-1:0] clr_ff, clr_in;
   logic signed [2*ValW+1:0] prod_ff, prod_in;
   // divider: numerator magnitude (delta*i up to 32 bits)
   logic [2:0] ch_ff, ch_in;
   logic [4:0] bit_ff, bit_in;
   logic [31:0] num_ff, num_in, quo_ff, quo_in;
   logic [RunW:0] rem_ff, rem_in;
   logic neg_ff, neg_in, div_busy_ff, div_busy_in;
   logic signed [ValW:0] samp_ff [5];
   logic signed [ValW:0] samp_in [5];
   logic out_valid_ff, out_valid_in;
   logic samp_done;

   always_ff @(posedge clock) begin
      if (wr_en) mem[wr_addr] <= wr_data;
      rd_ff <= mem[req_voice];
   end

   // step update combinational
   logic signed [ValW-1:0] t;
   logic signed [ValW+1:0] rnd;
   logic [15:0] lfsr_nx;
   always_comb begin
      rec_in = rec_ff;
      lfsr_in = lfsr_ff;
      lfsr_nx = {1'b0, lfsr_ff[15:1]} ^ (lfsr_ff[0] ? LfsrTaps : 16'h0);
      rnd = $signed({3'b000, lfsr_nx, 9'd0}) - $signed({{2{One[ValW-1]}}, One});
      t = '0;
      if (state_ff == ST_READ) begin
         rec_in = rd_ff;
      end else if (state_ff == ST_CALC) begin
         if (!rec_ff.trig_seen && trig_ff) begin
            rec_in.trig_seen = 1'b1;
            rec_in.tri_val = '0;
            rec_in.quad = QuadRise;
            rec_in.falling = 1'b0;
            rec_in.rect_tgt = MinusOne;
            rec_in.sine_tgt = '0;
         end
         if (rec_in.trig_seen && !trig_ff) rec_in.trig_seen = 1'b0;
         t = rec_in.tri_val;
         if (t >= One) begin
            rec_in.quad = QuadTop;
            rec_in.falling = 1'b1;
         end else if (t <= MinusOne) begin
            rec_in.quad = QuadBottom;
            rec_in.falling = 1'b0;
         end else if (rec_in.quad == QuadTop && t < 0) begin
            rec_in.quad = QuadFall;
            rec_in.rect_tgt = One;
            rec_in.hold_tgt = rnd[ValW-1:0];
            lfsr_in = lfsr_nx;
         end else if (rec_in.quad == QuadBottom && t > 0) begin
            rec_in.quad = QuadRise;
            rec_in.rect_tgt = MinusOne;
            rec_in.hold_tgt = rnd[ValW-1:0];
            lfsr_in = lfsr_nx;
            rec_in.saw_val = MinusOne;
         end
         rec_in.saw_val = sat26((ValW+2)'(rec_in.saw_val) +
                                $signed((ValW+2)'(step_ff[StepW-1:1])));
         if (rec_in.falling)
            rec_in.tri_val = sat26((ValW+2)'(t) - $signed((ValW+2)'(step_ff)));
         else
            rec_in.tri_val = sat26((ValW+2)'(t) + $signed((ValW+2)'(step_ff)));
      end else if (state_ff == ST_MUL) begin
         rec_in.sine_tgt = sat26((ValW+2)'(prod_ff >>> 24));
      end
   end

   // parabola product from the pre-step triangle value
   logic signed [ValW+1:0] fac;
   always_comb begin
      prod_in = prod_ff;
      fac = '0;
      if (state_ff == ST_CALC) begin
         // quadrants 0 and 1 take t*(2-t), the lower half t*(2+t)
         if (rec_in.quad[1] == 1'b0) fac = ((ValW+2)'(One) <<< 1) - (ValW+2)'(t);
         else fac = ((ValW+2)'(One) <<< 1) + (ValW+2)'(t);
         prod_in = (2*ValW+2)'(t) * (2*ValW+2)'(fac);
      end
   end

   // target of channel c
   function automatic logic signed [ValW-1:0] tgt(input voice_rec_type r, input logic [2:0] c);
      case (c)
         3'd0: return r.sine_tgt;
         3'd1: return r.tri_val;
         3'd2: return r.saw_val;
         3'd3: return r.rect_tgt;
         default: return r.hold_tgt;
      endcase
   endfunction

   logic signed [ValW:0] delta;
   logic signed [32:0] dprod;
   logic [RunW:0] rem_sh;
   always_comb begin
      state_in = state_ff;
      voice_in = voice_ff;
      trig_in = trig_ff;
      k_in = k_ff;
      i_in = i_ff;
      clr_in = clr_ff;
      ch_in = ch_ff;
      bit_in = bit_ff;
      num_in = num_ff;
      quo_in = quo_ff;
      rem_in = rem_ff;
      neg_in = neg_ff;
      div_busy_in = div_busy_ff;
      samp_in = samp_ff;
      out_valid_in = out_valid_ff;
      samp_done = 1'b0;
      wr_en = 1'b0;
      wr_addr = clr_ff;
      wr_data = rec_ff;
      req_ready = 1'b0;
      delta = '0;
      dprod = '0;
      rem_sh = '0;
      if (out_valid_ff && rsp_ready) out_valid_in = 1'b0;
      case (state_ff)
         ST_CLEAR: begin
            wr_en = 1'b1;
            wr_data = '{trig_seen: 1'b0, quad: QuadRise, falling: 1'b0, tri_val: '0,
                        saw_val: MinusOne, rect_tgt: '0, hold_tgt: '0, sine_tgt: '0,
                        prev: '0};
            clr_in = clr_ff + 1'b1;
            if (clr_ff == VoiceW'(Voices - 1)) state_in = ST_IDLE;
         end
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               voice_in = req_voice;
               trig_in = req_trigger_high;
               k_in = (req_run_length == '0) ? RunW'(1) :
                      (req_run_length > RunW'(MaxRun)) ? RunW'(MaxRun) : req_run_length;
               state_in = ST_READ;
            end
         end
         ST_READ: state_in = ST_CALC;
         ST_CALC: state_in = ST_MUL;
         ST_MUL: begin
            state_in = ST_EMIT;
            i_in = RunW'(1);
            ch_in = 3'd0;
            div_busy_in = 1'b0;
         end
         ST_EMIT: begin
            if (!out_valid_ff || rsp_ready) begin
               if (!div_busy_ff) begin
                  delta = (ValW+1)'(tgt(rec_ff, ch_ff)) -
                          (ValW+1)'($signed(rec_ff.prev[ch_ff]));
                  dprod = 33'(delta) * $signed({28'd0, i_ff});
                  neg_in = dprod[32];
                  num_in = dprod[32] ? 32'(-dprod) : dprod[31:0];
                  quo_in = '0;
                  rem_in = '0;
                  bit_in = 5'd31;
                  div_busy_in = 1'b1;
               end else begin
                  rem_sh = {rem_ff[RunW-1:0], num_ff[bit_ff]};
                  if (rem_sh >= {1'b0, k_ff}) begin
                     rem_in = rem_sh - {1'b0, k_ff};
                     quo_in[bit_ff] = 1'b1;
                  end else rem_in = rem_sh;
                  if (bit_ff == 5'd0) begin
                     div_busy_in = 1'b0;
                     samp_in[ch_ff] = (ValW+1)'($signed(rec_ff.prev[ch_ff])) +
                        (neg_ff ? -(ValW+1)'($signed({1'b0, quo_in[ValW:0]}))
                                : (ValW+1)'($signed({1'b0, quo_in[ValW:0]})));
                     if (ch_ff == 3'd4) begin
                        ch_in = 3'd0;
                        out_valid_in = 1'b1;
                        samp_done = 1'b1;
                        i_in = i_ff + 1'b1;
                        if (i_ff == k_ff) begin
                           for (int c = 0; c < 5; c++)
                              wr_data.prev[c] = tgt(rec_ff, 3'(c));
                           wr_en = 1'b1;
                           wr_addr = voice_ff;
                           state_in = ST_IDLE;
                        end
                     end else ch_in = ch_ff + 1'b1;
                  end else bit_in = bit_ff - 1'b1;
               end
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // voice and last flag travel with the sample so they hold while it waits
   logic last_ff;
   logic [VoiceW-1:0] voice_out_ff;
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_CLEAR;
         clr_ff <= '0;
         step_ff <= StepReset;
         lfsr_ff <= LfsrSeed;
         out_valid_ff <= 1'b0;
         div_busy_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         clr_ff <= clr_in;
         if (csr_valid) step_ff <= csr_tri_step;
         lfsr_ff <= lfsr_in;
         out_valid_ff <= out_valid_in;
         div_busy_ff <= div_busy_in;
      end
      voice_ff <= voice_in;
      trig_ff <= trig_in;
      k_ff <= k_in;
      i_ff <= i_in;
      ch_ff <= ch_in;
      bit_ff <= bit_in;
      num_ff <= num_in;
      quo_ff <= quo_in;
      rem_ff <= rem_in;
      neg_ff <= neg_in;
      samp_ff <= samp_in;
      rec_ff <= rec_in;
      prod_ff <= prod_in;
      if (samp_done) begin
         last_ff <= (i_ff == k_ff);
         voice_out_ff <= voice_ff;
      end
   end

   assign csr_ready = 1'b1;
   assign rsp_valid = out_valid_ff;
   assign rsp_sine_out = to_q14(samp_ff[0]);
   assign rsp_triangle_out = to_q14(samp_ff[1]);
   assign rsp_saw_up_out = to_q14(samp_ff[2]);
   assign rsp_saw_down_out = to_q14(-samp_ff[2]);
   assign rsp_rect_out = to_q14(samp_ff[3]);
   assign rsp_random_hold_out = to_q14(samp_ff[4]);
   assign rsp_voice_out = voice_out_ff;
   assign rsp_last_sample = last_ff;

   a_no_req_in_clear: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_CLEAR |-> !req_ready) else $error("request taken during clear");
   a_out_hold: assert property (@(posedge clock) disable iff (reset)
      out_valid_ff && !rsp_ready |=> out_valid_ff) else $error("response dropped");
   a_div_emit: assert property (@(posedge clock) disable iff (reset)
      state_ff != ST_EMIT |-> !div_busy_ff || state_ff == ST_IDLE)
      else $error("divider busy outside run");
endmodule

// ===== sim/multiwave_lfo_interpolated_test.sv =====
// Self-checking testbench for multiwave_lfo_interpolated: a driver and a monitor
// with random idling, a per-voice oscillator predictor and an in-order sample queue.
// Depends on mwlfo_pkg and the multiwave_lfo_interpolated RTL.
module multiwave_lfo_interpolated_test;
   timeunit 1ns;
   timeprecision 1ps;
   import mwlfo_pkg::*;

   typedef struct packed {
      logic [2:0] voice;
      logic       trig;
      logic [4:0] run;
   } step_req_type;

   typedef struct packed {
      logic [15:0] sine, tri_s, saw_up, saw_dn, rect, hold;
      logic [2:0]  voice;
      logic        last;
   } lfo_sample_type;

   logic clock = 0, reset = 1;
   logic csr_valid = 0, req_valid = 0, rsp_ready = 0;
   logic [StepW-1:0] csr_tri_step = '0;
   logic [2:0] req_voice = '0;
   logic req_trigger_high = 0;
   logic [4:0] req_run_length = 5'd1;
   logic csr_ready, req_ready, rsp_valid, rsp_last_sample;
   logic signed [15:0] rsp_sine_out, rsp_triangle_out, rsp_saw_up_out;
   logic signed [15:0] rsp_saw_down_out, rsp_rect_out, rsp_random_hold_out;
   logic [2:0] rsp_voice_out;

   multiwave_lfo_interpolated DUT (.*);

   always begin
      #6 clock = 1;
      #6 clock = 0;
   end

   // predictor state
   longint unsigned step_size;
   bit      trig_seen[8];
   bit [1:0] quad[8];
   bit      falling[8];
   longint  tri_v[8], saw_v[8], rect_t[8], hold_t[8], sine_t[8];
   longint  prev_v[8][5];
   bit [15:0] lfsr_v;

   step_req_type   pending_steps[$];
   lfo_sample_type expected_samples[$];
   int errors = 0, mismatches = 0;
   bit quiet = 0;   // stretch with no idling

   function automatic longint clamp26(longint x);
      if (x > 64'sd33554431) return 64'sd33554431;
      if (x < -64'sd33554432) return -64'sd33554432;
      return x;
   endfunction

   function automatic longint fl_shift(longint x, int s);
      return x >>> s;   // arithmetic shift is floor
   endfunction

   function automatic logic [15:0] q14(longint v);
      longint q;
      q = fl_shift(v, 10);
      if (q > 32767) q = 32767;
      if (q < -32768) q = -32768;
      return q[15:0];
   endfunction

   function automatic longint next_random();
      bit b;
      b = lfsr_v[0];
      lfsr_v = lfsr_v >> 1;
      if (b) lfsr_v ^= LfsrTaps;
      return (longint'(lfsr_v) << 9) - (64'sd1 << 24);
   endfunction

   task automatic reset_oscillators();
      step_size = StepReset;
      lfsr_v = LfsrSeed;
      for (int i = 0; i < 8; i++) begin
         trig_seen[i] = 0; quad[i] = QuadRise; falling[i] = 0;
         tri_v[i] = 0; saw_v[i] = -(64'sd1 << 24);
         rect_t[i] = 0; hold_t[i] = 0; sine_t[i] = 0;
         for (int j = 0; j < 5; j++) prev_v[i][j] = 0;
      end
   endtask

   task automatic advance_voice(step_req_type r);
      longint one, t, s;
      longint tg[5];
      int v, k;
      lfo_sample_type smp;
      one = 64'sd1 << 24;
      v = r.voice;
      k = r.run;
      if (k < 1) k = 1;
      if (k > MaxRun) k = MaxRun;
      if (!trig_seen[v] && r.trig) begin
         trig_seen[v] = 1; tri_v[v] = 0; quad[v] = QuadRise; falling[v] = 0;
         rect_t[v] = -one; sine_t[v] = 0;
      end
      if (trig_seen[v] && !r.trig) trig_seen[v] = 0;
      t = tri_v[v];
      if (t >= one) begin
         quad[v] = QuadTop; falling[v] = 1;
      end else if (t <= -one) begin
         quad[v] = QuadBottom; falling[v] = 0;
      end else if (quad[v] == QuadTop && t < 0) begin
         quad[v] = QuadFall; rect_t[v] = one; hold_t[v] = next_random();
      end else if (quad[v] == QuadBottom && t > 0) begin
         quad[v] = QuadRise; rect_t[v] = -one; hold_t[v] = next_random();
         saw_v[v] = -one;
      end
      if (quad[v] < QuadFall) sine_t[v] = clamp26(fl_shift(t * (2 * one - t), 24));
      else sine_t[v] = clamp26(fl_shift(t * (2 * one + t), 24));
      saw_v[v] = clamp26(saw_v[v] + longint'(step_size >> 1));
      tri_v[v] = falling[v] ? clamp26(t - longint'(step_size))
                            : clamp26(t + longint'(step_size));
      tg[0] = sine_t[v]; tg[1] = tri_v[v]; tg[2] = saw_v[v];
      tg[3] = rect_t[v]; tg[4] = hold_t[v];
      for (int i = 1; i <= k; i++) begin
         longint sv[5];
         for (int j = 0; j < 5; j++)
            sv[j] = prev_v[v][j] + ((tg[j] - prev_v[v][j]) * i) / k;
         smp.sine = q14(sv[0]); smp.tri_s = q14(sv[1]); smp.saw_up = q14(sv[2]);
         smp.saw_dn = q14(-sv[2]); smp.rect = q14(sv[3]); smp.hold = q14(sv[4]);
         smp.voice = v[2:0]; smp.last = (i == k);
         expected_samples.push_back(smp);
      end
      for (int j = 0; j < 5; j++) prev_v[v][j] = tg[j];
   endtask

   // driver
   always @(posedge clock) begin
      if (!reset) begin
         if (req_valid && req_ready) begin
            advance_voice(pending_steps.pop_front());
         end
         if ((!req_valid || req_ready) ) begin
            if (pending_steps.size() > (req_valid && req_ready ? 0 : 0)
                && (quiet || $urandom_range(99) >= 11)) begin
               req_valid <= 1;
               req_voice <= pending_steps[0].voice;
               req_trigger_high <= pending_steps[0].trig;
               req_run_length <= pending_steps[0].run;
            end else begin
               req_valid <= 0;
            end
         end
      end
   end

   // monitor
   always @(posedge clock) begin
      lfo_sample_type got, want;
      if (!reset) begin
         if (rsp_valid && rsp_ready) begin
            got = {rsp_sine_out, rsp_triangle_out, rsp_saw_up_out, rsp_saw_down_out,
                   rsp_rect_out, rsp_random_hold_out, rsp_voice_out, rsp_last_sample};
            if (expected_samples.size() == 0) begin
               errors++;
               if (mismatches++ < 10) $display("unexpected transaction %h", got);
            end else begin
               want = expected_samples.pop_front();
               if (got !== want) begin
                  errors++;
                  if (mismatches++ < 10)
                     $display("mismatch: expected %h actual %h", want, got);
               end
            end
         end
         rsp_ready <= quiet || $urandom_range(99) >= 11;
      end
   end

   task automatic write_step(logic [StepW-1:0] val);
      @(posedge clock);
      csr_valid <= 1;
      csr_tri_step <= val;
      do @(posedge clock); while (!csr_ready);
      step_size = val;
      csr_valid <= 0;
   endtask

   task automatic drain();
      while (pending_steps.size() != 0 || req_valid || expected_samples.size() != 0)
         @(posedge clock);
      repeat (100) @(posedge clock);
   endtask

   function automatic step_req_type mk(int v, bit tr, int run);
      step_req_type r;
      r.voice = v; r.trig = tr; r.run = run;
      return r;
   endfunction

   initial begin
      logic [StepW-1:0] steps[6];
      reset_oscillators();
      repeat (8) @(posedge clock);
      reset <= 0;
      // directed: extremes of fields, triggers, run lengths 0, 1, 24, 31
      pending_steps.push_back(mk(0, 0, 16));
      pending_steps.push_back(mk(7, 1, 1));
      pending_steps.push_back(mk(7, 1, 24));
      pending_steps.push_back(mk(7, 0, 0));
      pending_steps.push_back(mk(3, 1, 31));
      pending_steps.push_back(mk(5, 0, 21));
      drain();
      // zero step: triangle and saw stand still
      write_step('0);
      for (int i = 0; i < 4; i++) pending_steps.push_back(mk(i, i[0], 2));
      drain();
      // huge step: quadrants wrap fast; repeated triggers restart the triangle
      write_step(23'h7FFFFF);
      for (int i = 0; i < 14; i++) pending_steps.push_back(mk(1, i[0], 3));
      for (int i = 0; i < 4; i++) pending_steps.push_back(mk(2, 0, 2));
      drain();
      steps = '{23'd4194304, 23'd1, StepReset, 23'd2000000, 23'h7FFFFF, 23'd800000};
      for (int ph = 0; ph < 6; ph++) begin
         write_step(steps[ph]);
         quiet = (ph == 3);
         for (int i = 0; i < 74; i++) begin
            int run;
            run = ($urandom_range(9) == 0) ? $urandom_range(31) : $urandom_range(1, 6);
            pending_steps.push_back(mk($urandom_range(7), $urandom_range(99) < 15, run));
         end
         drain();
      end
      if (errors == 0 && expected_samples.size() == 0) begin
         $display("SCOREBOARD CLEAN");
      end else begin
         $display("SCOREBOARD MISMATCH");
      end
      $finish;
   end

   initial begin
      #200ms;
      $display("SCOREBOARD MISMATCH");
      $finish;
   end
endmodule
